[rtl/u2cp_pkg.sv]
// Package for the UTF-8 to code point decoder.
// Holds the channel payload structs, the status codes and the decode constants.
// No dependencies.
package u2cp_pkg;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_FE_FF    = 3'd1,
    ST_TOO_LONG     = 3'd2,
    ST_STRAY_CONT   = 3'd3,
    ST_OVERLONG     = 3'd4,
    ST_UNTERMINATED = 3'd5,
    ST_ABORTED      = 3'd6
  } status_t;

  // One input byte of the string.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       string_end;
  } u2cp_in_t;

  // One decoded result.
  typedef struct packed {
    logic [20:0] code_point;
    status_t     status;
    logic        last_result;
  } u2cp_out_t;

  localparam int unsigned CpWidth = 21;

  // Smallest legal value for each sequence length (overlong check).
  localparam logic [CpWidth-1:0] FloorFourByte  = 21'h010000;
  localparam logic [CpWidth-1:0] FloorThreeByte = 21'h000800;
  localparam logic [CpWidth-1:0] FloorTwoByte   = 21'h000080;

  // Byte payload masks and the lowest FE/FF lead byte value.
  localparam logic [7:0] MaskAscii   = 8'h7F;
  localparam logic [7:0] MaskLead2   = 8'h1F;
  localparam logic [7:0] MaskLead3   = 8'h0F;
  localparam logic [7:0] MaskLead4   = 8'h07;
  localparam logic [7:0] MaskCont    = 8'h3F;
  localparam logic [7:0] ByteFe      = 8'hFE;

endpackage

[rtl/utf8_to_codepoint_decoder_unit.sv]
// Top level of the UTF-8 to code point decoder: input register, decode logic
// and result register in one module.
// Depends on u2cp_pkg for payload types, status codes and constants.
//
//   channel | direction | ports                        | payload
//   --------+-----------+------------------------------+-------------
//   in      | input     | in_valid, in_ready, in_data  | u2cp_in_t
//   out     | output    | out_valid, out_ready, out_data | u2cp_out_t
//   cfg     | input     | cfg_we, cfg_wdata            | strict_mode
//
// One byte is taken per clock while the result side does not stall; the byte that
// completes a result is held in the input register, and the result register is loaded as it leaves.
// Bytes that complete nothing advance through the input register without a result.
// A stalled result holds the result register, which holds the input register,
// which in turn drops in_ready; the stall reaches the input in the same cycle.
// Synchronous active-low reset clears the valid flags, decode state and strict_mode.
module utf8_to_codepoint_decoder_unit
  import u2cp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  u2cp_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output u2cp_out_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  logic             strict_mode_r;
  logic             in_valid_r;
  u2cp_in_t         in_data_r;
  logic             out_valid_r;
  u2cp_out_t        out_data_r;
  logic [CpWidth-1:0] partial_r, partial_nxt;
  logic [1:0]       rem_r, rem_nxt;
  logic [1:0]       seq_len_r, seq_len_nxt;
  logic             error_seen_r, error_seen_nxt;
  logic             advance;
  logic             emit;
  u2cp_out_t        result;
  logic [CpWidth-1:0] shifted;
  logic [CpWidth-1:0] floor_value;
  logic [7:0]       b;
  logic             str_end;

  // The held byte moves on when the result register is free or being drained.
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strict_mode_r <= 1'b0;
    end else if (cfg_we) begin
      strict_mode_r <= cfg_wdata;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  assign b       = in_data_r.data_byte;
  assign str_end = in_data_r.string_end;
  assign shifted = {partial_r[CpWidth-7:0], b[5:0]};

  // Smallest value a sequence of the open length may legally encode.
  always_comb begin
    case (seq_len_r)
      2'd3:    floor_value = FloorFourByte;
      2'd2:    floor_value = FloorThreeByte;
      default: floor_value = FloorTwoByte;
    endcase
  end

  // Decode of one byte against the sequence state.
  always_comb begin
    partial_nxt    = partial_r;
    rem_nxt        = rem_r;
    seq_len_nxt    = seq_len_r;
    error_seen_nxt = error_seen_r;
    emit           = 1'b0;
    result.code_point  = '0;
    result.status      = ST_OK;
    result.last_result = str_end;

    if (error_seen_r) begin
      // Drop bytes until the string ends, then mark the abort.
      if (str_end) begin
        emit           = 1'b1;
        result.status  = ST_ABORTED;
        error_seen_nxt = 1'b0;
        partial_nxt    = '0;
        rem_nxt        = '0;
        seq_len_nxt    = '0;
      end
    end else if (rem_r != 2'd0) begin
      // Continuation byte: gather six more payload bits.
      if (rem_r == 2'd1) begin
        emit        = 1'b1;
        partial_nxt = '0;
        rem_nxt     = '0;
        seq_len_nxt = '0;
        if (strict_mode_r && (shifted < floor_value)) begin
          result.status  = ST_OVERLONG;
          error_seen_nxt = !str_end;
        end else begin
          result.code_point = shifted;
        end
      end else if (str_end) begin
        emit          = 1'b1;
        result.status = ST_UNTERMINATED;
        partial_nxt   = '0;
        rem_nxt       = '0;
        seq_len_nxt   = '0;
      end else begin
        partial_nxt = shifted;
        rem_nxt     = rem_r - 2'd1;
      end
    end else begin
      // Lead position.
      if (strict_mode_r && (b >= ByteFe)) begin
        emit           = 1'b1;
        result.status  = ST_BAD_FE_FF;
        error_seen_nxt = !str_end;
      end else if (!b[7]) begin
        emit              = 1'b1;
        result.code_point = CpWidth'(b & MaskAscii);
      end else if (!b[6]) begin
        emit           = 1'b1;
        result.status  = ST_STRAY_CONT;
        error_seen_nxt = !str_end;
      end else if (b[7:3] == 5'b11111) begin
        emit           = 1'b1;
        result.status  = ST_TOO_LONG;
        error_seen_nxt = !str_end;
      end else if (str_end) begin
        emit          = 1'b1;
        result.status = ST_UNTERMINATED;
      end else if (b[7:4] == 4'b1111) begin
        partial_nxt = CpWidth'(b & MaskLead4);
        rem_nxt     = 2'd3;
        seq_len_nxt = 2'd3;
      end else if (b[7:5] == 3'b111) begin
        partial_nxt = CpWidth'(b & MaskLead3);
        rem_nxt     = 2'd2;
        seq_len_nxt = 2'd2;
      end else begin
        partial_nxt = CpWidth'(b & MaskLead2);
        rem_nxt     = 2'd1;
        seq_len_nxt = 2'd1;
      end
    end
  end

  // Sequence state, updated as each byte leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r    <= '0;
      rem_r        <= '0;
      seq_len_r    <= '0;
      error_seen_r <= 1'b0;
    end else if (advance) begin
      partial_r    <= partial_nxt;
      rem_r        <= rem_nxt;
      seq_len_r    <= seq_len_nxt;
      error_seen_r <= error_seen_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= advance && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_data_r <= result;
    end
  end

  // An error state never coexists with an open sequence.
  assert property (@(posedge clk) disable iff (!rst_n)
    !(error_seen_r && (rem_r != 2'd0)))
    else $error("error flag set while a sequence is open");

  // Bytes still expected never exceed the length of the open sequence.
  assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= seq_len_r)
    else $error("remaining count exceeds sequence length");

  // A failed result carries no code point.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status != ST_OK)) |-> (out_data_r.code_point == '0))
    else $error("error result with nonzero code point");

  // An abort marker always closes the string.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status == ST_ABORTED)) |-> out_data_r.last_result)
    else $error("abort marker without last_result");

  // The final byte of a string leaves the decoder in its start state.
  assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_data_r.string_end) |=> ((rem_r == 2'd0) && !error_seen_r))
    else $error("state not cleared at string end");

endmodule

[tb/utf8_to_codepoint_decoder_unit_tb.sv]
// Self-checking testbench for utf8_to_codepoint_decoder_unit: directed and random
// byte strings, with a scoreboard class that decodes each accepted byte itself.
// Depends on u2cp_pkg and the decoder RTL.
module utf8_to_codepoint_decoder_unit_tb;
  import u2cp_pkg::*;

  // Tracks the decode state and the results still to come from the block.
  class decode_scoreboard;
    bit          strict;
    logic [20:0] partial;
    logic [1:0]  remaining;
    logic [1:0]  seq_len;
    bit          in_error;
    u2cp_out_t   pending_results[$];
    int unsigned errors;
    int unsigned results_seen;

    function void clear_seq();
      partial   = '0;
      remaining = '0;
      seq_len   = '0;
    endfunction

    function void push(logic [20:0] cp, status_t st, logic last);
      u2cp_out_t r;
      r.code_point  = cp;
      r.status      = st;
      r.last_result = last;
      pending_results.push_back(r);
    endfunction

    // An error clears the open sequence; bytes are dropped until the string ends.
    function void reject(status_t st, logic fin);
      clear_seq();
      in_error = !fin;
      push('0, st, fin);
    endfunction

    // Notes one accepted byte and queues the result it causes, if any.
    function void note_byte(u2cp_in_t item);
      logic [7:0]  b;
      logic        fin;
      logic [20:0] floor_cp;
      b   = item.data_byte;
      fin = item.string_end;
      if (in_error) begin
        if (fin) begin
          in_error = 1'b0;
          clear_seq();
          push('0, ST_ABORTED, 1'b1);
        end
        return;
      end
      // Following byte of an open sequence: any value, low six bits taken.
      if (remaining != 0) begin
        partial   = {partial[14:0], b[5:0]};
        remaining = remaining - 2'd1;
        if (remaining == 0) begin
          if (seq_len == 2'd3) begin
            floor_cp = FloorFourByte;
          end else if (seq_len == 2'd2) begin
            floor_cp = FloorThreeByte;
          end else begin
            floor_cp = FloorTwoByte;
          end
          if (strict && partial < floor_cp) begin
            reject(ST_OVERLONG, fin);
          end else begin
            push(partial, ST_OK, fin);
            clear_seq();
          end
        end else if (fin) begin
          clear_seq();
          push('0, ST_UNTERMINATED, 1'b1);
        end
        return;
      end
      // Byte at lead position.
      if (strict && b >= ByteFe) begin
        reject(ST_BAD_FE_FF, fin);
      end else if (!b[7]) begin
        push({14'd0, b[6:0]}, ST_OK, fin);
      end else if (!b[6]) begin
        reject(ST_STRAY_CONT, fin);
      end else if (b[7:3] == 5'b11111) begin
        reject(ST_TOO_LONG, fin);
      end else if (fin) begin
        clear_seq();
        push('0, ST_UNTERMINATED, 1'b1);
      end else if (b[7:4] == 4'hF) begin
        partial   = {18'd0, b[2:0]};
        remaining = 2'd3;
        seq_len   = 2'd3;
      end else if (b[7:5] == 3'b111) begin
        partial   = {17'd0, b[3:0]};
        remaining = 2'd2;
        seq_len   = 2'd2;
      end else begin
        partial   = {16'd0, b[4:0]};
        remaining = 2'd1;
        seq_len   = 2'd1;
      end
    endfunction

    // Compares one result transfer with the oldest expectation.
    function void check_result(u2cp_out_t got);
      u2cp_out_t exp_r;
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, got cp %h status %0d last %b",
                 $time, got.code_point, got.status, got.last_result);
        return;
      end
      exp_r = pending_results.pop_front();
      if (got.code_point !== exp_r.code_point) begin
        errors++;
        $display("%0t: code_point mismatch, expected %h, got %h",
                 $time, exp_r.code_point, got.code_point);
      end
      if (got.status !== exp_r.status) begin
        errors++;
        $display("%0t: status mismatch, expected %0d, got %0d",
                 $time, exp_r.status, got.status);
      end
      if (got.last_result !== exp_r.last_result) begin
        errors++;
        $display("%0t: last_result mismatch, expected %b, got %b",
                 $time, exp_r.last_result, got.last_result);
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  u2cp_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  u2cp_out_t out_data;
  logic      cfg_we    = 1'b0;
  logic      cfg_wdata = 1'b0;

  decode_scoreboard sb = new();
  bit          quiet;
  bit          pressure_done;
  int unsigned bytes_sent;

  utf8_to_codepoint_decoder_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("utf8_to_codepoint_decoder_unit verification failed");
    $finish;
  end

  // Offers one byte, with an occasional gap before it, and waits for its transfer.
  task automatic send_byte(logic [7:0] b, logic fin);
    u2cp_in_t item;
    item.data_byte  = b;
    item.string_end = fin;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(item);
    bytes_sent++;
  endtask

  // Stops offering and waits until every result is in and the pipeline is empty.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_strict(bit v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.strict = v;
  endtask

  function automatic logic [7:0] follow_byte();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // Builds one string of mostly well-formed characters, sometimes cut short.
  task automatic send_random_string();
    logic [7:0] string_bytes[$];
    int         chars;
    int         pick;
    int         keep;
    chars = $urandom_range(1, 12);
    for (int c = 0; c < chars; c++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        string_bytes.push_back(8'($urandom_range(0, 127)));
      end else if (pick < 55) begin
        string_bytes.push_back(8'hC0 | 8'($urandom_range(0, 31)));
        string_bytes.push_back(follow_byte());
      end else if (pick < 70) begin
        string_bytes.push_back(8'hE0 | 8'($urandom_range(0, 15)));
        repeat (2) string_bytes.push_back(follow_byte());
      end else if (pick < 85) begin
        string_bytes.push_back(8'hF0 | 8'($urandom_range(0, 7)));
        repeat (3) string_bytes.push_back(follow_byte());
      end else begin
        string_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      keep = $urandom_range(1, string_bytes.size());
      while (string_bytes.size() > keep) void'(string_bytes.pop_back());
    end
    foreach (string_bytes[i]) send_byte(string_bytes[i], i == string_bytes.size() - 1);
  endtask

  // Result side: random stalls, one long hold-off, none at the end of the run.
  initial begin
    wait (rst_n === 1'b1);
    forever begin
      if (!pressure_done && sb.results_seen >= 150) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        pressure_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // Result transfers are checked as they happen.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_data);
    end
  end

  initial begin
    int unsigned target;
    sb.clear_seq();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed strings with strict mode at its reset value.
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
    send_byte(8'hC2, 1'b0);
    send_byte(8'hA9, 1'b1);
    send_byte(8'hF4, 1'b0);
    send_byte(8'h8F, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
    // Largest value; a following byte of any value is masked to six bits.
    send_byte(8'hF7, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hBF, 1'b1);
    send_byte(8'hFE, 1'b1);
    // Too long lead before the end, then the aborted marker.
    send_byte(8'hFF, 1'b0);
    send_byte(8'h41, 1'b1);
    send_byte(8'h80, 1'b1);
    // String ends on the lead byte, then inside a sequence.
    send_byte(8'hE0, 1'b1);
    send_byte(8'hE0, 1'b0);
    send_byte(8'h80, 1'b1);
    // Leave a sequence open across the switch to strict mode.
    send_byte(8'hC1, 1'b0);
    set_strict(1'b1);
    send_byte(8'hBF, 1'b1);
    send_byte(8'hC0, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hE0, 1'b0);
    send_byte(8'h9F, 1'b0);
    send_byte(8'hBF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h41, 1'b1);
    send_byte(8'hFE, 1'b1);

    // Random strings, alternating strict mode; the last phase runs without idling.
    for (int ph = 0; ph < 4; ph++) begin
      set_strict(ph % 2 == 1);
      if (ph == 3) quiet = 1'b1;
      target = bytes_sent + 470;
      while (bytes_sent < target) send_random_string();
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("utf8_to_codepoint_decoder_unit verification clean");
    end else begin
      $display("utf8_to_codepoint_decoder_unit verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/u2cp_pkg.sv
rtl/utf8_to_codepoint_decoder_unit.sv
tb/utf8_to_codepoint_decoder_unit_tb.sv
